// ----- hw/rtl/igemv_pkg.sv -----
// Shared constants, register codes and types for the int8 row-scaled GEMV block.
`timescale 1ns / 1ps
package igemv_pkg;

	localparam int LANES          = 4;
	localparam int LG_LANES       = $clog2(LANES);
	localparam int SAT_BLOCK      = 32;
	localparam int MAX_LENGTH_DEF = 8192;

	localparam int VLEN_W   = 14;
	localparam int SCALE_W  = 16;
	localparam int RCOUNT_W = 17;
	localparam int ROW_W    = 16;
	localparam int SUM_W    = 32;
	localparam int VAL_W    = 48;
	localparam int CFG_W    = 17;
	localparam int CFG_IDX_W = 2;

	localparam int PROD_W = 17;
	localparam int LSUM_W = PROD_W + LG_LANES;

	localparam logic [CFG_IDX_W-1:0] REG_VLEN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ASCALE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RCOUNT = 2'd2;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_WGT  = 1'b1;

	localparam logic [VLEN_W-1:0]   VLEN_RST   = 14'd2560;
	localparam logic [SCALE_W-1:0]  ASCALE_RST = 16'd655;
	localparam logic [RCOUNT_W-1:0] RCOUNT_RST = 17'd10240;

	typedef logic [7:0]                act_t;
	typedef logic signed [7:0]         wgt_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;

	typedef struct packed {
		logic vld;
		logic last;
		logic sat;
	} ctl_t;

endpackage

// ----- hw/rtl/int8_gemv_row_scaled.sv -----
// Top level of the int8 matrix-vector block with per-row scaling.
//
//  channel   direction  handshake                 payload
//  item      in         item_valid / item_stall   mode, act0..act3, wgt0..wgt3, row_scale
//  result    out        result_valid/result_stall row_number, dot_sum, scaled_value
//  cfg       in         cfg_we (no wait)          cfg_index, cfg_data
//
// One item per cycle for both loads and weights, unless item_stall holds it. A row result passes
// through the RAM read, lane multiply and merge registers after the weight item ending the row
// is taken, then is scaled into the output register.
// While an earlier row result is still in the pipeline or unsent in the output register,
// any item is stalled when the weight position sits on the row's last word; otherwise
// items are never stalled.
// Reset clears positions, accumulator, row counter and registers; the activation
// RAM is not cleared.
`timescale 1ns / 1ps
module int8_gemv_row_scaled #(
	parameter int MAX_LENGTH = igemv_pkg::MAX_LENGTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  logic                                  mode,
	input  igemv_pkg::act_t                       act0,
	input  igemv_pkg::act_t                       act1,
	input  igemv_pkg::act_t                       act2,
	input  igemv_pkg::act_t                       act3,
	input  igemv_pkg::wgt_t                       wgt0,
	input  igemv_pkg::wgt_t                       wgt1,
	input  igemv_pkg::wgt_t                       wgt2,
	input  igemv_pkg::wgt_t                       wgt3,
	input  logic [igemv_pkg::SCALE_W-1:0]         row_scale,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic [igemv_pkg::ROW_W-1:0]           row_number,
	output igemv_pkg::sum_t                       dot_sum,
	output logic signed [igemv_pkg::VAL_W-1:0]    scaled_value,
	input  logic                                  cfg_we,
	input  logic [igemv_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [igemv_pkg::CFG_W-1:0]           cfg_data
);
	import igemv_pkg::*;

	localparam int DEPTH     = MAX_LENGTH / LANES;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int VW_W      = VLEN_W - LG_LANES;
	localparam int CW        = (CNT_W > VW_W) ? CNT_W : VW_W;
	localparam int SAT_WORDS = SAT_BLOCK / LANES;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	// configuration
	logic [VLEN_W-1:0]   vlen_q;
	logic [SCALE_W-1:0]  ascale_q;
	logic [RCOUNT_W-1:0] rcount_q;

	// positions are in words of LANES bytes
	logic [ADDR_W-1:0]   lpos_q;
	logic [ADDR_W-1:0]   wpos_q;
	logic [ROW_W-1:0]    row_q;

	logic [CW-1:0]       vl_words;
	logic [CW-1:0]       lw;
	logic [CW-1:0]       satw;
	logic [ADDR_W-1:0]   lpos_eff;
	logic [ADDR_W-1:0]   wpos_eff;
	logic [CW-1:0]       lnext;
	logic [CW-1:0]       wnext;
	logic                lend;
	logic                wend;
	logic [RCOUNT_W-1:0] rc_lim;
	logic [RCOUNT_W-1:0] rc_nx;

	logic                acc_in;
	logic                acc_l;
	logic                acc_w;
	logic                busy;

	ctl_t                ctl_s1;
	ctl_t                ctl_s2;
	ctl_t                ctl_s3;
	wgt_t                wgt_s1 [LANES];
	logic [SCALE_W-1:0]  rscale_s1;
	logic [ROW_W-1:0]    row_s1;
	logic [ROW_W-1:0]    row_s2;
	logic [ROW_W-1:0]    row_s3;
	logic [8*LANES-1:0]  wdata;
	logic [8*LANES-1:0]  rdata_s1;
	prod_t               prod_s2 [LANES];
	sum_t                sum_s3;
	logic signed [VAL_W-1:0] scaled_s3;

	logic                result_valid_q;
	logic [ROW_W-1:0]    row_number_q;
	sum_t                dot_sum_q;
	logic signed [VAL_W-1:0] scaled_value_q;

	// effective length in words: rounded down, capped at the RAM depth, at least one word
	always_comb begin
		vl_words = CW'(vlen_q[VLEN_W-1:LG_LANES]);
		if (vl_words > DEPTH_C) begin
			lw = DEPTH_C;
		end else if (vl_words == '0) begin
			lw = CW'(1);
		end else begin
			lw = vl_words;
		end
		satw = CW'((lw / SAT_WORDS) * SAT_WORDS);

		lpos_eff = (CW'(lpos_q) >= lw) ? '0 : lpos_q;
		wpos_eff = (CW'(wpos_q) >= lw) ? '0 : wpos_q;
		lnext    = CW'(lpos_eff) + CW'(1);
		wnext    = CW'(wpos_eff) + CW'(1);
		lend     = lnext >= lw;
		wend     = wnext >= lw;

		if (rcount_q == '0) begin
			rc_lim = RCOUNT_W'(1);
		end else if (rcount_q > RCOUNT_W'(65536)) begin
			rc_lim = RCOUNT_W'(65536);
		end else begin
			rc_lim = rcount_q;
		end
		rc_nx = RCOUNT_W'(row_q) + RCOUNT_W'(1);
	end

	assign busy       = ctl_s1.last | ctl_s2.last | ctl_s3.last | result_valid_q;
	assign item_stall = wend & busy;
	assign acc_in     = item_valid & ~item_stall;
	assign acc_l      = acc_in & (mode == MODE_LOAD);
	assign acc_w      = acc_in & (mode == MODE_WGT);
	assign wdata      = {act3, act2, act1, act0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlen_q   <= VLEN_RST;
			ascale_q <= ASCALE_RST;
			rcount_q <= RCOUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VLEN:   vlen_q   <= cfg_data[VLEN_W-1:0];
				REG_ASCALE: ascale_q <= cfg_data[SCALE_W-1:0];
				REG_RCOUNT: rcount_q <= cfg_data[RCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpos_q <= '0;
			wpos_q <= '0;
			row_q  <= '0;
		end else begin
			if (acc_l) begin
				lpos_q <= lend ? '0 : lnext[ADDR_W-1:0];
			end
			if (acc_w) begin
				wpos_q <= wend ? '0 : wnext[ADDR_W-1:0];
				if (wend) begin
					row_q <= (rc_nx >= rc_lim) ? '0 : rc_nx[ROW_W-1:0];
				end
			end
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1.vld  <= acc_w;
			ctl_s1.last <= acc_w & wend;
			ctl_s1.sat  <= CW'(wpos_eff) < satw;
			ctl_s2      <= ctl_s1;
			ctl_s3      <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_w) begin
			wgt_s1[0] <= wgt0;
			wgt_s1[1] <= wgt1;
			wgt_s1[2] <= wgt2;
			wgt_s1[3] <= wgt3;
			rscale_s1 <= row_scale;
			row_s1    <= row_q;
		end
		row_s2 <= row_s1;
		row_s3 <= row_s2;
	end

	igemv_ram #(
		.WIDTH(8 * LANES),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (acc_l),
		.waddr (lpos_eff),
		.wdata (wdata),
		.re    (acc_w),
		.raddr (wpos_eff),
		.rdata (rdata_s1)
	);

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		igemv_lane u_lane (
			.clk     (clk),
			.act     (rdata_s1[8*k +: 8]),
			.wgt     (wgt_s1[k]),
			.prod_s2 (prod_s2[k])
		);
	end

	igemv_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s2  (ctl_s2),
		.prod_s2 (prod_s2),
		.sum_s3  (sum_s3)
	);

	igemv_scale u_scale (
		.clk       (clk),
		.ascale    (ascale_q),
		.rscale_s1 (rscale_s1),
		.sum_s3    (sum_s3),
		.scaled    (scaled_s3)
	);

	// output register; busy guarantees it is empty when a row result arrives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctl_s3.last) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s3.last) begin
			row_number_q   <= row_s3;
			dot_sum_q      <= sum_s3;
			scaled_value_q <= scaled_s3;
		end
	end

	assign result_valid = result_valid_q;
	assign row_number   = row_number_q;
	assign dot_sum      = dot_sum_q;
	assign scaled_value = scaled_value_q;

endmodule

// ----- hw/rtl/igemv_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module igemv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/igemv_lane.sv -----
// One multiply lane: unsigned activation times signed weight, registered.
`timescale 1ns / 1ps
module igemv_lane (
	input  logic           clk,
	input  igemv_pkg::act_t  act,
	input  igemv_pkg::wgt_t  wgt,
	output igemv_pkg::prod_t prod_s2
);
	import igemv_pkg::*;

	always_ff @(posedge clk) begin
		prod_s2 <= $signed({1'b0, act}) * wgt;
	end

endmodule

// ----- hw/rtl/igemv_merge.sv -----
// Lane merge: saturating pair sums or exact sum, and the row accumulator.
`timescale 1ns / 1ps
module igemv_merge (
	input  logic             clk,
	input  logic             arst_n,
	input  igemv_pkg::ctl_t  ctl_s2,
	input  igemv_pkg::prod_t prod_s2 [igemv_pkg::LANES],
	output igemv_pkg::sum_t  sum_s3
);
	import igemv_pkg::*;

	localparam logic signed [PROD_W:0] SAT_HI = 18'sd32767;
	localparam logic signed [PROD_W:0] SAT_LO = -18'sd32768;

	logic signed [PROD_W:0]   pair;
	logic signed [LSUM_W-1:0] sat_sum;
	logic signed [LSUM_W-1:0] raw_sum;
	logic signed [LSUM_W-1:0] lane_sum;
	sum_t                     acc_q;
	sum_t                     acc_nx;

	always_comb begin
		sat_sum = '0;
		raw_sum = '0;
		pair    = '0;
		for (int j = 0; j < LANES / 2; j++) begin
			pair = (PROD_W+1)'(prod_s2[2*j]) + (PROD_W+1)'(prod_s2[2*j+1]);
			if (pair > SAT_HI) begin
				pair = SAT_HI;
			end else if (pair < SAT_LO) begin
				pair = SAT_LO;
			end
			sat_sum = sat_sum + LSUM_W'(pair);
		end
		for (int k = 0; k < LANES; k++) begin
			raw_sum = raw_sum + LSUM_W'(prod_s2[k]);
		end
		lane_sum = ctl_s2.sat ? sat_sum : raw_sum;
		acc_nx   = acc_q + SUM_W'(lane_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl_s2.vld) begin
			acc_q <= ctl_s2.last ? '0 : acc_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.vld && ctl_s2.last) begin
			sum_s3 <= acc_nx;
		end
	end

endmodule

// ----- hw/rtl/igemv_scale.sv -----
// Row scaling: activation scale times row scale, then times the row sum, Q.16 result.
`timescale 1ns / 1ps
module igemv_scale (
	input  logic                                  clk,
	input  logic [igemv_pkg::SCALE_W-1:0]         ascale,
	input  logic [igemv_pkg::SCALE_W-1:0]         rscale_s1,
	input  igemv_pkg::sum_t                       sum_s3,
	output logic signed [igemv_pkg::VAL_W-1:0]    scaled
);
	import igemv_pkg::*;

	logic [2*SCALE_W-1:0]         scl_s2;
	logic [2*SCALE_W-1:0]         scl_s3;
	logic signed [2*SUM_W-1:0]    prod;

	always_ff @(posedge clk) begin
		scl_s2 <= ascale * rscale_s1;
		scl_s3 <= scl_s2;
	end

	// 32 x 33 signed product always fits in 64 bits; shift right by 16 keeps 48
	assign prod   = sum_s3 * $signed({1'b0, scl_s3});
	assign scaled = prod[2*SUM_W-1 -: VAL_W];

endmodule

// ----- dv/int8_gemv_row_scaled_chk.sv -----
// Row-result predictor and scoreboard for the int8 row-scaled GEMV block.
`timescale 1ns / 1ps
module int8_gemv_row_scaled_chk (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	input  logic                               item_stall,
	input  logic                               mode,
	input  igemv_pkg::act_t                    act0,
	input  igemv_pkg::act_t                    act1,
	input  igemv_pkg::act_t                    act2,
	input  igemv_pkg::act_t                    act3,
	input  igemv_pkg::wgt_t                    wgt0,
	input  igemv_pkg::wgt_t                    wgt1,
	input  igemv_pkg::wgt_t                    wgt2,
	input  igemv_pkg::wgt_t                    wgt3,
	input  logic [igemv_pkg::SCALE_W-1:0]      row_scale,
	input  logic                               result_valid,
	input  logic                               result_stall,
	input  logic [igemv_pkg::ROW_W-1:0]        row_number,
	input  igemv_pkg::sum_t                    dot_sum,
	input  logic signed [igemv_pkg::VAL_W-1:0] scaled_value,
	input  logic                               cfg_we,
	input  logic [igemv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [igemv_pkg::CFG_W-1:0]        cfg_data,
	output int                                 fail_count,
	output int                                 rows_pending
);
	import igemv_pkg::*;

	localparam int MAX_PRINTS = 100;

	typedef struct packed {
		logic [ROW_W-1:0]        row;
		logic signed [SUM_W-1:0] sum;
		logic signed [VAL_W-1:0] val;
	} row_result_t;

	row_result_t rows_due[$];

	act_t                act_mem [MAX_LENGTH_DEF];
	logic [VLEN_W-1:0]   vlen_reg;
	logic [SCALE_W-1:0]  ascale_reg;
	logic [RCOUNT_W-1:0] rcount_reg;
	int unsigned         load_at;
	int unsigned         wgt_at;
	int unsigned         row_ctr;
	logic [SUM_W-1:0]    acc;
	int                  mismatches = 0;

	// Length as the block uses it: whole lanes, capped at the store size, never below one lane.
	function automatic int unsigned row_length();
		int unsigned n;
		int unsigned cap;
		cap = (MAX_LENGTH_DEF / LANES) * LANES;
		n = (int'(vlen_reg) / LANES) * LANES;
		if (n > cap)
			n = cap;
		if (n < LANES)
			n = LANES;
		return n;
	endfunction

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_result();
		row_result_t want;
		if (rows_due.size() == 0) begin
			report($sformatf("result row %0d sum %0d with no row outstanding",
				row_number, dot_sum));
		end else begin
			want = rows_due.pop_front();
			if (row_number !== want.row)
				report($sformatf("row_number %0d, predicted %0d", row_number, want.row));
			if (dot_sum !== want.sum)
				report($sformatf("row %0d dot_sum %0d, predicted %0d",
					want.row, dot_sum, want.sum));
			if (scaled_value !== want.val)
				report($sformatf("row %0d scaled_value %0d, predicted %0d",
					want.row, scaled_value, want.val));
		end
	endtask

	task automatic predict_item();
		int unsigned n;
		int unsigned sat_end;
		int unsigned k;
		int unsigned limit;
		int          p0;
		int          p1;
		int          pair;
		act_t        a [LANES];
		wgt_t        w [LANES];
		longint      s;
		longint      m;
		longint      prod;
		logic [63:0] shifted;
		row_result_t r;

		a = '{act0, act1, act2, act3};
		w = '{wgt0, wgt1, wgt2, wgt3};
		n = row_length();

		if (mode == MODE_LOAD) begin
			if (load_at >= n)
				load_at = 0;
			for (int i = 0; i < LANES; i++)
				act_mem[load_at + i] = a[i];
			load_at += LANES;
			if (load_at >= n)
				load_at = 0;
			return;
		end

		// a length change can leave the position past the new end
		if (wgt_at >= n)
			wgt_at = 0;
		sat_end = (n / SAT_BLOCK) * SAT_BLOCK;
		k = 0;
		while (k < LANES) begin
			p0 = int'(act_mem[wgt_at + k]) * int'(w[k]);
			if (k + 1 < LANES && wgt_at + k + 1 < sat_end) begin
				// maddubs-style pair: add, then clamp to int16
				p1 = int'(act_mem[wgt_at + k + 1]) * int'(w[k + 1]);
				pair = p0 + p1;
				if (pair > 32767)
					pair = 32767;
				else if (pair < -32768)
					pair = -32768;
				acc = acc + pair;
				k += 2;
			end else begin
				acc = acc + p0;
				k += 1;
			end
		end
		wgt_at += LANES;
		if (wgt_at < n)
			return;

		s = $signed(acc);
		m = ascale_reg * row_scale;
		prod = s * m;
		shifted = prod >>> 16;
		r.row = row_ctr[ROW_W-1:0];
		r.sum = acc;
		r.val = shifted[VAL_W-1:0];
		rows_due.push_back(r);

		acc = '0;
		wgt_at = 0;
		limit = rcount_reg;
		if (limit == 0)
			limit = 1;
		if (limit > 65536)
			limit = 65536;
		row_ctr = row_ctr + 1;
		if (row_ctr >= limit)
			row_ctr = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_due.delete();
			vlen_reg = VLEN_RST;
			ascale_reg = ASCALE_RST;
			rcount_reg = RCOUNT_RST;
			load_at = 0;
			wgt_at = 0;
			row_ctr = 0;
			acc = '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_VLEN:   vlen_reg = cfg_data[VLEN_W-1:0];
					REG_ASCALE: ascale_reg = cfg_data[SCALE_W-1:0];
					REG_RCOUNT: rcount_reg = cfg_data[RCOUNT_W-1:0];
					default: ;
				endcase
			end
			// a result leaving now was started by an item taken earlier
			if (result_valid && !result_stall)
				check_result();
			if (item_valid && !item_stall)
				predict_item();
		end
		rows_pending <= rows_due.size();
		fail_count <= mismatches;
	end

endmodule

// ----- dv/int8_gemv_row_scaled_tb.sv -----
// Testbench top for the int8 row-scaled GEMV block: stimulus, flow-control pressure, verdict.
`timescale 1ns / 1ps
module int8_gemv_row_scaled_tb;
	import igemv_pkg::*;

	localparam int N_PHASES      = 8;
	localparam int IDLE_PCT      = 12;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 12;
	localparam int WATCHDOG      = 2000;

	// index 3 decodes to no register
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// per phase: raw length, loads needed to fill the row, row count, mixed items, load share
	int vlen_tab     [N_PHASES] = '{0, 8, 37, 64, 100, 12, 250, 44};
	int fill_tab     [N_PHASES] = '{1, 2, 9, 16, 25, 3, 62, 11};
	int rcount_tab   [N_PHASES] = '{1, 131071, 0, 5, 65536, 4, 2, 3};
	int mix_tab      [N_PHASES] = '{150, 120, 150, 200, 150, 100, 100, 120};
	int load_pct_tab [N_PHASES] = '{10, 10, 15, 10, 10, 20, 0, 10};

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    item_valid = 1'b0;
	logic                    item_stall;
	logic                    mode = MODE_LOAD;
	act_t                    act0 = '0;
	act_t                    act1 = '0;
	act_t                    act2 = '0;
	act_t                    act3 = '0;
	wgt_t                    wgt0 = '0;
	wgt_t                    wgt1 = '0;
	wgt_t                    wgt2 = '0;
	wgt_t                    wgt3 = '0;
	logic [SCALE_W-1:0]      row_scale = '0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	logic [ROW_W-1:0]        row_number;
	sum_t                    dot_sum;
	logic signed [VAL_W-1:0] scaled_value;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = REG_VLEN;
	logic [CFG_W-1:0]        cfg_data = '0;

	int fail_count;
	int rows_pending;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	int holds_asked = 0;
	int holds_done = 0;
	int quiet_cycles = 0;

	int8_gemv_row_scaled dut (.*);

	int8_gemv_row_scaled_chk chk (.*);

	always #1 clk = ~clk;

	// byte lanes biased toward the saturating corners
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '1;
			1: return '0;
			2: return 32'h8080_8080;
			3: return 32'h7F7F_7F7F;
			default: return $urandom();
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic send_item(input logic m, input logic [31:0] acts, input logic [31:0] wgts,
			input logic [SCALE_W-1:0] rs);
		while (!tx_calm && $urandom_range(0, 99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		mode <= m;
		{act3, act2, act1, act0} <= acts;
		{wgt3, wgt2, wgt1, wgt0} <= wgts;
		row_scale <= rs;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic send_mix(input int n, input int load_pct);
		repeat (n) begin
			if ($urandom_range(0, 99) < load_pct)
				send_item(MODE_LOAD, pick_word(), $urandom(), 16'($urandom()));
			else
				send_item(MODE_WGT, $urandom(), pick_word(), 16'($urandom()));
		end
	endtask

	// wait out every outstanding row, then let the pipe go quiet
	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (rows_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (holds_done != holds_asked) begin
				holds_done++;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result_stall <= !rx_calm && $urandom_range(0, 99) < IDLE_PCT;
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 36 elements: 32 paired and saturating, last four summed exactly
		write_reg(REG_VLEN, 17'd36);
		write_reg(REG_RCOUNT, 17'd3);
		write_reg(REG_SPARE, 17'($urandom()));
		cfg_we <= 1'b0;
		repeat (8) send_item(MODE_LOAD, '1, $urandom(), 16'($urandom()));
		send_item(MODE_LOAD, 32'h007F_80FF, $urandom(), 16'($urandom()));
		repeat (9) send_item(MODE_WGT, $urandom(), 32'h8080_8080, 16'hFFFF);
		repeat (9) send_item(MODE_WGT, $urandom(), 32'h7F7F_7F7F, 16'h0000);
		drain();

		for (int p = 0; p < N_PHASES; p++) begin
			tx_calm = (p == 1);
			rx_calm = (p == 1);
			write_reg(REG_VLEN, {3'($urandom()), 14'(vlen_tab[p])});
			write_reg(REG_ASCALE, {1'($urandom()),
				16'(p == 0 ? 65535 : p == 1 ? 0 : $urandom())});
			write_reg(REG_RCOUNT, 17'(rcount_tab[p]));
			cfg_we <= 1'b0;
			// one full pass over the row so no weight reads an unwritten entry
			repeat (fill_tab[p]) send_item(MODE_LOAD, pick_word(), $urandom(), 16'($urandom()));
			if (p == 0)
				holds_asked++;
			if (p == 3) begin
				send_mix(mix_tab[p] / 2, load_pct_tab[p]);
				drain();
				send_mix(mix_tab[p] - mix_tab[p] / 2, load_pct_tab[p]);
			end else begin
				send_mix(mix_tab[p], load_pct_tab[p]);
			end
			drain();
		end

		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
